/* design/bdeq_pkg.sv */
package bdeq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK = 3'd1;
	localparam logic [2:0] OP_POP_FRONT = 3'd2;
	localparam logic [2:0] OP_POP_BACK = 3'd3;
	localparam logic [2:0] OP_LIST = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] opcode;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic has_value;
		logic signed [DATA_W-1:0] item;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic rotate;
	} cell_cmd_t;

endpackage

/* design/bdeq_cell.sv */
module bdeq_cell #(
	parameter int DEPTH = bdeq_pkg::DEPTH_DEF,
	parameter int IDX = 0
) (
	input logic clk,
	input bdeq_pkg::cell_cmd_t cmd,
	input logic [$clog2(DEPTH+1)-1:0] occ,
	input logic signed [bdeq_pkg::DATA_W-1:0] value,
	input logic signed [bdeq_pkg::DATA_W-1:0] prev_d,
	input logic signed [bdeq_pkg::DATA_W-1:0] next_d,
	input logic signed [bdeq_pkg::DATA_W-1:0] head_d,
	output logic signed [bdeq_pkg::DATA_W-1:0] d,
	output logic is_tail
);
	import bdeq_pkg::*;

	localparam int OCC_W = $clog2(DEPTH+1);
	localparam logic [OCC_W-1:0] AT = OCC_W'(IDX);
	localparam logic [OCC_W-1:0] NEXT = OCC_W'(IDX + 1);

	logic signed [DATA_W-1:0] d_q;

	// shift toward the back, append, shift toward the front, or rotate the occupied span
	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			d_q <= prev_d;
		end else if (cmd.push_back && (occ == AT)) begin
			d_q <= value;
		end else if (cmd.pop_front) begin
			d_q <= next_d;
		end else if (cmd.rotate) begin
			if (NEXT < occ) begin
				d_q <= next_d;
			end else if (NEXT == occ) begin
				d_q <= head_d;
			end
		end
	end

	assign d = d_q;
	assign is_tail = (NEXT == occ);

endmodule

/* design/bounded_double_ended_queue.sv */
// Deque of up to DEPTH signed 32-bit values held in a row of cells, front value in
// cell zero. Each input word is one operation: push front, push back, pop front,
// pop back or list. A push or a pop is accepted and yields one result word in the
// next cycle; the next input word can follow in the next cycle as long as the
// output register drains. A list of N stored values is accepted first, then gives
// one result per cycle while the output is not stalled, as the occupied cells
// rotate one step toward the front with each result, so after N steps they are
// back in place. No input is taken until the last listed value has entered the
// output register, and output stalls pause the listing. A list on an empty deque
// yields one empty result. A push on a full deque reports full and leaves the
// contents alone; opcodes above list produce nothing. No clearing pass follows reset.
module bounded_double_ended_queue #(
	parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bdeq_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output bdeq_pkg::out_word_t out_data
);
	import bdeq_pkg::*;

	localparam int OCC_W = $clog2(DEPTH+1);
	localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(DEPTH);
	localparam logic [OCC_W-1:0] ONE = OCC_W'(1);

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] list_left_q;
	logic list_busy_q;
	logic out_valid_q;
	out_word_t out_data_q;

	logic signed [DATA_W-1:0] cell_d [DEPTH];
	logic [DEPTH-1:0] cell_tail;
	logic signed [DATA_W-1:0] tail_d;
	cell_cmd_t cmd;

	logic in_fire;
	logic out_free;
	logic full;
	logic empty;
	logic res_valid;
	out_word_t res;
	logic occ_inc;
	logic occ_dec;
	logic list_start;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !list_busy_q && out_free;
	assign in_fire = in_valid && in_ready;
	assign full = (occ_q == FULL_CNT);
	assign empty = (occ_q == '0);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_d;
		logic signed [DATA_W-1:0] next_d;
		if (i == 0) begin : g_head
			assign prev_d = in_data.value;
		end else begin : g_mid
			assign prev_d = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign next_d = cell_d[i];
		end else begin : g_inner
			assign next_d = cell_d[i+1];
		end
		bdeq_cell #(
			.DEPTH(DEPTH),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.occ(occ_q),
			.value(in_data.value),
			.prev_d(prev_d),
			.next_d(next_d),
			.head_d(cell_d[0]),
			.d(cell_d[i]),
			.is_tail(cell_tail[i])
		);
	end

	always_comb begin
		tail_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_tail[i]) begin
				tail_d = tail_d | cell_d[i];
			end
		end
	end

	always_comb begin
		cmd = '0;
		res_valid = 1'b0;
		res = '0;
		res.last = 1'b1;
		occ_inc = 1'b0;
		occ_dec = 1'b0;
		list_start = 1'b0;
		if (list_busy_q) begin
			if (out_free) begin
				cmd.rotate = 1'b1;
				res_valid = 1'b1;
				res.status = ST_OK;
				res.has_value = 1'b1;
				res.item = cell_d[0];
				res.last = (list_left_q == ONE);
			end
		end else if (in_fire) begin
			unique case (in_data.opcode) inside
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					res_valid = 1'b1;
					if (full) begin
						res.status = ST_FULL;
					end else begin
						res.status = ST_OK;
						occ_inc = 1'b1;
						cmd.push_front = (in_data.opcode == OP_PUSH_FRONT);
						cmd.push_back = (in_data.opcode == OP_PUSH_BACK);
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					res_valid = 1'b1;
					if (empty) begin
						res.status = ST_EMPTY;
					end else begin
						res.status = ST_OK;
						res.has_value = 1'b1;
						occ_dec = 1'b1;
						if (in_data.opcode == OP_POP_FRONT) begin
							res.item = cell_d[0];
							cmd.pop_front = 1'b1;
						end else begin
							res.item = tail_d;
						end
					end
				end
				OP_LIST: begin
					if (empty) begin
						res_valid = 1'b1;
						res.status = ST_EMPTY;
					end else begin
						list_start = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			list_busy_q <= 1'b0;
			list_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (occ_inc) begin
				occ_q <= occ_q + ONE;
			end else if (occ_dec) begin
				occ_q <= occ_q - ONE;
			end
			if (list_start) begin
				list_busy_q <= 1'b1;
				list_left_q <= occ_q;
			end else if (list_busy_q && out_free) begin
				list_left_q <= list_left_q - ONE;
				if (list_left_q == ONE) begin
					list_busy_q <= 1'b0;
				end
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_CNT)
		else $error("occupancy above depth");

	a_list_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		list_busy_q |-> (!in_ready && list_left_q != '0 && list_left_q <= occ_q))
		else $error("listing state inconsistent");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && full && (in_data.opcode == OP_PUSH_FRONT ||
			in_data.opcode == OP_PUSH_BACK))
		|=> (out_valid_q && out_data_q.status == ST_FULL && $stable(occ_q)))
		else $error("push on full deque not refused");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !empty && (in_data.opcode == OP_POP_FRONT ||
			in_data.opcode == OP_POP_BACK))
		|=> (occ_q == $past(occ_q) - ONE && out_data_q.has_value))
		else $error("pop did not remove a value");

endmodule

/* sim/tb_bounded_double_ended_queue.sv */
module tb_bounded_double_ended_queue;
	import bdeq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int RANDOM_WORDS = 175;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 24;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_PATTERN} drain_mode_t;
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	typedef struct {
		in_word_t word;
		int reps;
		bit typed;
		out_word_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	logic signed [DATA_W-1:0] model_slots [DEPTH];
	logic [IDX_W-1:0] model_front;
	logic [$clog2(DEPTH+1)-1:0] model_count;
	out_word_t pending_results [$];
	stim_row_t directed_rows [$];

	int mismatches = 0;
	int words_sent = 0;
	int results_seen = 0;
	int listings = 0;
	int longest_listing = 0;
	int full_refusals = 0;
	int empty_answers = 0;
	int burst_left = 1;
	int idle_cycles = 0;
	int drain_cycle = 0;
	drain_mode_t drain_mode = DRAIN_FREE;
	out_word_t head;

	bounded_double_ended_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_word_t result_word(input logic [1:0] status, input logic has,
			input logic signed [DATA_W-1:0] item, input logic last);
		out_word_t r;
		r.status = status;
		r.has_value = has;
		r.item = item;
		r.last = last;
		return r;
	endfunction

	function automatic void predict_deque(input in_word_t w);
		int slot;
		int n;
		case (w.opcode) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					pending_results.push_back(result_word(ST_FULL, 1'b0, '0, 1'b1));
					full_refusals++;
				end else begin
					if (w.opcode == OP_PUSH_FRONT) begin
						model_front = IDX_W'((int'(model_front) + DEPTH - 1) % DEPTH);
						slot = int'(model_front);
					end else begin
						slot = (int'(model_front) + int'(model_count)) % DEPTH;
					end
					model_slots[slot] = w.value;
					model_count++;
					pending_results.push_back(result_word(ST_OK, 1'b0, '0, 1'b1));
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (model_count == 0) begin
					pending_results.push_back(result_word(ST_EMPTY, 1'b0, '0, 1'b1));
					empty_answers++;
				end else begin
					if (w.opcode == OP_POP_FRONT) begin
						slot = int'(model_front);
						model_front = IDX_W'((int'(model_front) + 1) % DEPTH);
					end else begin
						slot = (int'(model_front) + int'(model_count) - 1) % DEPTH;
					end
					model_count--;
					pending_results.push_back(result_word(ST_OK, 1'b1, model_slots[slot], 1'b1));
				end
			end
			OP_LIST: begin
				n = int'(model_count);
				if (n == 0) begin
					pending_results.push_back(result_word(ST_EMPTY, 1'b0, '0, 1'b1));
					empty_answers++;
				end else begin
					for (int i = 0; i < n; i++) begin
						slot = (int'(model_front) + i) % DEPTH;
						pending_results.push_back(result_word(ST_OK, 1'b1, model_slots[slot],
							i == n - 1));
					end
					listings++;
					if (n > longest_listing)
						longest_listing = n;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(input logic [2:0] opcode, input logic [31:0] value,
			input int reps, input bit typed, input logic [1:0] status, input logic has,
			input logic [31:0] item);
		stim_row_t r;
		r.word.opcode = opcode;
		r.word.value = value;
		r.reps = reps;
		r.typed = typed;
		r.want = result_word(status, has, item, 1'b1);
		directed_rows.push_back(r);
	endfunction

	function automatic in_word_t random_word(input op_mix_t mix);
		in_word_t w;
		int roll;
		int push_share;
		roll = $urandom_range(0, 99);
		push_share = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 25 : 43;
		if (roll < 4)
			w.opcode = 3'(OP_UNUSED_LO + $urandom_range(0, 2));
		else if (roll < 14)
			w.opcode = OP_LIST;
		else if (roll < 14 + push_share)
			w.opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		else
			w.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
		case ($urandom_range(0, 11))
			0: w.value = 32'h7FFF_FFFF;
			1: w.value = 32'h8000_0000;
			2: w.value = '0;
			3: w.value = '1;
			default: w.value = $urandom();
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string field, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("%0t: result %0d field %s got %0d want %0d", $realtime, results_seen, field,
			got, want);
		mismatches++;
	endtask

	task automatic issue_word(input in_word_t w, input bit typed, input out_word_t want);
		int gap;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_deque(w);
		if (typed)
			pending_results[pending_results.size() - 1] = want;
		words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	always @(posedge clk) begin
		drain_cycle++;
		if (drain_cycle % 80 == 0)
			drain_mode = drain_mode_t'($urandom_range(0, 3));
		case (drain_mode)
			DRAIN_FREE: out_ready <= 1'b1;
			DRAIN_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
			DRAIN_HEAVY: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= (drain_cycle[2:0] != 3'b011) && (drain_cycle[2:0] != 3'b100);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, out_data);
				mismatches++;
			end else begin
				head = pending_results.pop_front();
				if (out_data.status !== head.status)
					report_mismatch("status", 32'(out_data.status), 32'(head.status));
				if (out_data.has_value !== head.has_value)
					report_mismatch("has_value", 32'(out_data.has_value),
						32'(head.has_value));
				if (out_data.item !== head.item)
					report_mismatch("item", out_data.item, head.item);
				if (out_data.last !== head.last)
					report_mismatch("last", 32'(out_data.last), 32'(head.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding", $realtime,
				idle_cycles, pending_results.size());
			$display("tb_bounded_double_ended_queue: FAIL");
			$finish;
		end
	end

	initial begin
		op_mix_t mix;
		mix = MIX_EVEN;
		model_front = '0;
		model_count = '0;
		foreach (model_slots[i])
			model_slots[i] = '0;

		add_row(OP_POP_FRONT, 32'h0000_0001, 1, 1'b1, ST_EMPTY, 1'b0, '0);
		add_row(OP_POP_BACK, 32'hFFFF_FFFE, 1, 1'b1, ST_EMPTY, 1'b0, '0);
		add_row(OP_LIST, 32'h1234_5678, 1, 1'b1, ST_EMPTY, 1'b0, '0);
		add_row(OP_UNUSED_LO, 32'h0000_0005, 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_UNUSED_HI, 32'h7FFF_FFFF, 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_BACK, 32'h8000_0000, 1, 1'b1, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_BACK, 32'h0000_0000, 1, 1'b1, ST_OK, 1'b0, '0);
		add_row(OP_LIST, 32'h0, 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_POP_FRONT, 32'h0, 1, 1'b1, ST_OK, 1'b1, 32'hFFFF_FFFF);
		add_row(OP_POP_BACK, 32'h0, 1, 1'b1, ST_OK, 1'b1, 32'h0000_0000);
		add_row(OP_PUSH_BACK, 32'h5A5A_5A5A, DEPTH / 2 - 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_FRONT, 32'hA5A5_A5A5, DEPTH / 2 - 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_PUSH_FRONT, 32'h0000_0001, 1, 1'b1, ST_FULL, 1'b0, '0);
		add_row(OP_PUSH_BACK, 32'h0000_0002, 1, 1'b1, ST_FULL, 1'b0, '0);
		add_row(OP_LIST, 32'hFFFF_FFFF, 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_UNUSED_MID, 32'h8000_0000, 1, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_POP_FRONT, 32'h0, DEPTH / 2, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_POP_BACK, 32'h0, DEPTH / 2, 1'b0, ST_OK, 1'b0, '0);
		add_row(OP_POP_BACK, 32'h0, 1, 1'b1, ST_EMPTY, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			repeat (directed_rows[r].reps)
				issue_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 22 == 0)
				mix = op_mix_t'($urandom_range(0, 2));
			issue_word(random_word(mix), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d words in, %0d results checked, %0d listings (longest %0d)",
			words_sent, results_seen, listings, longest_listing);
		$display("run: %0d pushes refused on a full deque, %0d empty answers",
			full_refusals, empty_answers);
		if (mismatches == 0)
			$display("tb_bounded_double_ended_queue: PASS");
		else
			$display("tb_bounded_double_ended_queue: FAIL");
		$finish;
	end

endmodule
